[design/accumulator_cpu_core_assert.svh]
// ----------------------------------------------------------------------------
// Accumulator CPU core assertion macros
// Shared forms for the concurrent checks of the core, clocked on i_clk and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_CORE_ASSERT_SVH
`define ACCUMULATOR_CPU_CORE_ASSERT_SVH

// Same-cycle implication.
`define ACC_CPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACC_CPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/acc_cpu_pkg.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU package
// Memory map constants, opcodes, flag and fault codes, sequencer types and
// the access permission checks of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_cpu_pkg;

    // Call stack placement.
    localparam int unsigned STACK_BASE_PAGE = 64;
    localparam int unsigned STACK_PAGES     = 32;
    localparam logic [15:0] STACK_BASE      = 16'(STACK_BASE_PAGE * 256);
    localparam logic [16:0] STACK_LIMIT     = 17'(STACK_PAGES * 256);

    // Memory map pages and console registers.
    localparam logic [7:0] RAM_PAGE      = 8'h80;
    localparam logic [7:0] PROT_LO_PAGE  = 8'h40;
    localparam logic [7:0] PROT_HI_PAGE  = 8'h5F;
    localparam logic [7:0] CON_PAGE      = 8'h60;
    localparam logic [7:0] CON_OUT_LO    = 8'h00;
    localparam logic [7:0] CON_STAT_LO   = 8'h02;
    localparam logic [7:0] CON_LAST_LO   = 8'h05;
    localparam logic [7:0] CON_READY     = 8'h10;
    localparam logic [15:0] CON_STAT_ADR = {CON_PAGE, CON_STAT_LO};

    // Flags, one-hot.
    localparam logic [3:0] FLG_NEG = 4'h1;
    localparam logic [3:0] FLG_ZRO = 4'h2;
    localparam logic [3:0] FLG_POS = 4'h4;
    localparam logic [3:0] FLG_OVF = 4'h8;

    // Run states.
    localparam logic [1:0] RUN_GO    = 2'd0;
    localparam logic [1:0] RUN_HALT  = 2'd1;
    localparam logic [1:0] RUN_FAULT = 2'd2;

    // Fault codes.
    localparam logic [2:0] F_NONE  = 3'd0;
    localparam logic [2:0] F_LOAD  = 3'd1;
    localparam logic [2:0] F_STORE = 3'd2;
    localparam logic [2:0] F_JUMP  = 3'd3;
    localparam logic [2:0] F_UNDER = 3'd4;
    localparam logic [2:0] F_OPC   = 3'd5;
    localparam logic [2:0] F_FETCH = 3'd6;

    // Addressing modes (opcode bits 7:5).
    localparam logic [2:0] MODE_IMM = 3'd0;
    localparam logic [2:0] MODE_IDX = 3'd2;
    localparam logic [2:0] MODE_DXI = 3'd3;
    localparam logic [2:0] MODE_PTR = 3'd4;

    // Opcode groups by low five bits.
    localparam logic [4:0] LO_LD  = 5'h02;
    localparam logic [4:0] LO_ST  = 5'h03;
    localparam logic [4:0] LO_LDX = 5'h04;
    localparam logic [4:0] LO_ADD = 5'h0C;
    localparam logic [4:0] LO_SUB = 5'h0D;
    localparam logic [4:0] LO_AND = 5'h18;
    localparam logic [4:0] LO_OR  = 5'h19;
    localparam logic [4:0] LO_XOR = 5'h1A;

    // Single opcodes.
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_STX  = 8'h25;
    localparam logic [7:0] OP_INC  = 8'h08;
    localparam logic [7:0] OP_DEC  = 8'h09;
    localparam logic [7:0] OP_INX  = 8'h0A;
    localparam logic [7:0] OP_DEX  = 8'h0B;
    localparam logic [7:0] OP_SHL  = 8'h0E;
    localparam logic [7:0] OP_ROL  = 8'h1E;
    localparam logic [7:0] OP_SHR  = 8'h0F;
    localparam logic [7:0] OP_ROR  = 8'h1F;
    localparam logic [7:0] OP_NOT  = 8'h1B;
    localparam logic [7:0] OP_RET  = 8'h15;
    localparam logic [7:0] OP_HALT = 8'hFF;

    // Jump conditions (opcode bits 2:0).
    localparam logic [2:0] JC_ALW = 3'd0;
    localparam logic [2:0] JC_ZRO = 3'd1;
    localparam logic [2:0] JC_POS = 3'd2;
    localparam logic [2:0] JC_NEG = 3'd3;
    localparam logic [2:0] JC_OVF = 3'd4;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_WAIT = 5'b00100,
        S_WR   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // What the current memory access is for.
    typedef enum logic [4:0] {
        P_OP, P_IMM, P_OPER, P_A0, P_A1, P_PTR0, P_PTR1, P_IX0, P_IX1,
        P_JA0, P_JA1, P_JT0, P_JT1, P_JD0, P_JD1, P_RT0, P_RT1,
        P_ST, P_SX0, P_SX1, P_PU0, P_PU1
    } t_phase;

    // Kind of memory-operand instruction.
    typedef enum logic [2:0] {
        K_LD, K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_ST, K_STX
    } t_kind;

    // Read permission; sys opens the protected stack region.
    function automatic logic rd_ok(input logic [15:0] ad, input logic sys);
        logic ok;
        if (ad[15:8] >= RAM_PAGE) begin
            ok = 1'b1;
        end else if (ad[15:8] == CON_PAGE && ad[7:0] <= CON_LAST_LO) begin
            ok = (ad[7:0] == CON_STAT_LO);
        end else if (ad[15:8] < PROT_LO_PAGE) begin
            ok = 1'b1;
        end else if (ad[15:8] <= PROT_HI_PAGE) begin
            ok = sys;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // Write permission; ROM and the unmapped ports always refuse.
    function automatic logic wr_ok(input logic [15:0] ad, input logic sys);
        logic ok;
        if (ad[15:8] >= RAM_PAGE) begin
            ok = 1'b1;
        end else if (ad[15:8] == CON_PAGE && ad[7:0] <= CON_LAST_LO) begin
            ok = (ad[7:0] == CON_OUT_LO);
        end else if (ad[15:8] >= PROT_LO_PAGE && ad[15:8] <= PROT_HI_PAGE) begin
            ok = sys;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[design/accumulator_cpu_core.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU core
// 8-bit accumulator machine over a 64K byte map held in one synchronous RAM,
// run one instruction per step beat by a memory sequencer.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid/o_ready) takes one beat at a time. A
// command of 0 preloads i_data at i_address; a command of 1 runs one
// instruction. Every input beat gives exactly one result beat on the output
// channel (o_valid/i_ready) with the registers, run state, latched fault code
// and any console byte written by that step.
// Steps: a step reads each byte through S_ACC and S_WAIT and writes each byte
// in S_WR; a preload goes straight to S_DONE, where the result is held.
// Throughput: one beat in flight; o_ready returns the cycle after the result
// is taken.
// Reset: registers, stack pointer, console status and run state clear; RAM
// contents are undefined until preloaded. A stalled receiver holds the result
// and the core takes no new beat until it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_cpu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_run_state,
    output logic [2:0]       o_fault_code,
    output logic [7:0]       o_accumulator,
    output logic [15:0]      o_index_value,
    output logic [3:0]       o_flag_bits,
    output logic [15:0]      o_program_counter,
    output logic             o_console_valid,
    output logic [7:0]       o_console_char
);

    // Sequencer and architectural registers.
    acc_cpu_pkg::t_state r_state, n_state;
    acc_cpu_pkg::t_phase r_ph, n_ph;
    acc_cpu_pkg::t_kind  r_kind, n_kind;
    logic [2:0]  r_mode, n_mode;
    logic [7:0]  r_op, n_op;
    logic [15:0] r_addr, n_addr;
    logic        r_sys, n_sys;
    logic [2:0]  r_fc, n_fc;
    logic [7:0]  r_hi, n_hi;
    logic [7:0]  r_wdata, n_wdata;
    logic [7:0]  r_acc, n_acc;
    logic [15:0] r_idx, n_idx;
    logic [15:0] r_pc, n_pc;
    logic [3:0]  r_flg, n_flg;
    logic [15:0] r_sp, n_sp;
    logic [7:0]  r_cstat, n_cstat;
    logic [1:0]  r_stop, n_stop;
    logic [2:0]  r_fault, n_fault;
    logic        r_con_v, n_con_v;
    logic [7:0]  r_con_c, n_con_c;

    // Memory: ROM at the bottom, stack and RAM above, addressed directly.
    logic [7:0]  mem [65536];
    logic [7:0]  r_rdata;
    logic        w_we;
    logic [15:0] w_wa;
    logic [7:0]  w_wd;
    logic [7:0]  w_rd;

    // ALU results for a fetched operand.
    logic [8:0]  w_sum;
    logic [7:0]  w_diff;
    logic [7:0]  w_x_acc;
    logic [3:0]  w_x_flg;

    // Read data, with the console status register mapped in.
    assign w_rd = (r_addr == acc_cpu_pkg::CON_STAT_ADR) ? r_cstat : r_rdata;

    // Operand execution.
    assign w_sum  = {1'b0, r_acc} + {1'b0, w_rd};
    assign w_diff = r_acc - w_rd;

    always_comb begin
        w_x_acc = r_acc;
        w_x_flg = r_flg;
        case (r_kind)
            acc_cpu_pkg::K_LD: w_x_acc = w_rd;
            acc_cpu_pkg::K_ADD: begin
                w_x_acc = w_sum[7:0];
                if (w_sum[8]) begin
                    w_x_flg = acc_cpu_pkg::FLG_OVF;
                end else if (w_sum[7:0] == 8'h00) begin
                    w_x_flg = acc_cpu_pkg::FLG_ZRO;
                end else begin
                    w_x_flg = acc_cpu_pkg::FLG_POS;
                end
            end
            acc_cpu_pkg::K_SUB: begin
                w_x_acc = w_diff;
                if (w_diff == 8'h00) begin
                    w_x_flg = acc_cpu_pkg::FLG_ZRO;
                end else if (w_rd > r_acc) begin
                    w_x_flg = acc_cpu_pkg::FLG_NEG;
                end else begin
                    w_x_flg = acc_cpu_pkg::FLG_POS;
                end
            end
            acc_cpu_pkg::K_AND: w_x_acc = r_acc & w_rd;
            acc_cpu_pkg::K_OR:  w_x_acc = r_acc | w_rd;
            acc_cpu_pkg::K_XOR: w_x_acc = r_acc ^ w_rd;
            default: w_x_acc = r_acc;
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb begin
        logic        do_use;
        logic [15:0] ea;
        logic [2:0]  md;
        logic [4:0]  lo5;
        logic        cond_ok;
        logic        jstart;

        n_state = r_state;  n_ph = r_ph;     n_kind = r_kind;   n_mode = r_mode;
        n_op = r_op;        n_addr = r_addr; n_sys = r_sys;     n_fc = r_fc;
        n_hi = r_hi;        n_wdata = r_wdata;
        n_acc = r_acc;      n_idx = r_idx;   n_pc = r_pc;       n_flg = r_flg;
        n_sp = r_sp;        n_cstat = r_cstat; n_stop = r_stop; n_fault = r_fault;
        n_con_v = r_con_v;  n_con_c = r_con_c;
        w_we = 1'b0;        w_wa = r_addr;   w_wd = r_wdata;
        do_use = 1'b0;      ea = r_idx;      jstart = 1'b0;
        md = w_rd[7:5];     lo5 = w_rd[4:0]; cond_ok = 1'b0;

        case (r_state)
            // Take a beat: preload at once, or start the opcode fetch when running.
            acc_cpu_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_con_v = 1'b0;
                    n_con_c = 8'h00;
                    n_state = acc_cpu_pkg::S_DONE;
                    if (!i_command) begin
                        if (i_address == acc_cpu_pkg::CON_STAT_ADR) begin
                            n_cstat = i_data;
                        end else begin
                            w_we = 1'b1;
                            w_wa = i_address;
                            w_wd = i_data;
                        end
                    end else if (r_stop == acc_cpu_pkg::RUN_GO) begin
                        n_addr  = r_pc;
                        n_sys   = 1'b0;
                        n_fc    = acc_cpu_pkg::F_LOAD;
                        n_ph    = acc_cpu_pkg::P_OP;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                end
            end

            // Issue a read if it is permitted.
            acc_cpu_pkg::S_ACC: begin
                if (acc_cpu_pkg::rd_ok(r_addr, r_sys)) begin
                    n_state = acc_cpu_pkg::S_WAIT;
                end else begin
                    n_stop  = acc_cpu_pkg::RUN_FAULT;
                    n_fault = r_fc;
                    n_state = acc_cpu_pkg::S_DONE;
                end
            end

            // Read data is back: act on it by phase.
            acc_cpu_pkg::S_WAIT: begin
                n_state = acc_cpu_pkg::S_DONE;
                case (r_ph)
                    acc_cpu_pkg::P_OP: begin
                        n_op   = w_rd;
                        n_mode = md;
                        n_pc   = r_pc + 16'd1;
                        if (((lo5 == acc_cpu_pkg::LO_LD || lo5 == acc_cpu_pkg::LO_ADD ||
                              lo5 == acc_cpu_pkg::LO_SUB || lo5 == acc_cpu_pkg::LO_AND ||
                              lo5 == acc_cpu_pkg::LO_OR || lo5 == acc_cpu_pkg::LO_XOR)
                             && md <= acc_cpu_pkg::MODE_PTR)
                            || (lo5 == acc_cpu_pkg::LO_ST && md != acc_cpu_pkg::MODE_IMM
                                && md <= acc_cpu_pkg::MODE_PTR)
                            || w_rd == acc_cpu_pkg::OP_STX) begin
                            // Memory-operand group: pick the kind, then the mode.
                            case (lo5)
                                acc_cpu_pkg::LO_LD:  n_kind = acc_cpu_pkg::K_LD;
                                acc_cpu_pkg::LO_ST:  n_kind = acc_cpu_pkg::K_ST;
                                acc_cpu_pkg::LO_ADD: n_kind = acc_cpu_pkg::K_ADD;
                                acc_cpu_pkg::LO_SUB: n_kind = acc_cpu_pkg::K_SUB;
                                acc_cpu_pkg::LO_AND: n_kind = acc_cpu_pkg::K_AND;
                                acc_cpu_pkg::LO_OR:  n_kind = acc_cpu_pkg::K_OR;
                                acc_cpu_pkg::LO_XOR: n_kind = acc_cpu_pkg::K_XOR;
                                default:             n_kind = acc_cpu_pkg::K_STX;
                            endcase
                            if (md == acc_cpu_pkg::MODE_IMM) begin
                                n_addr  = r_pc + 16'd1;
                                n_sys   = 1'b0;
                                n_fc    = acc_cpu_pkg::F_LOAD;
                                n_ph    = acc_cpu_pkg::P_IMM;
                                n_state = acc_cpu_pkg::S_ACC;
                            end else if (md == acc_cpu_pkg::MODE_IDX) begin
                                do_use = 1'b1;
                                ea     = r_idx;
                            end else begin
                                n_addr  = r_pc + 16'd1;
                                n_sys   = 1'b1;
                                n_fc    = acc_cpu_pkg::F_FETCH;
                                n_ph    = acc_cpu_pkg::P_A0;
                                n_state = acc_cpu_pkg::S_ACC;
                            end
                        end else if (lo5 == acc_cpu_pkg::LO_LDX && md <= 3'd1) begin
                            n_addr  = r_pc + 16'd1;
                            n_sys   = 1'b0;
                            n_fc    = acc_cpu_pkg::F_LOAD;
                            n_ph    = acc_cpu_pkg::P_IX0;
                            n_state = acc_cpu_pkg::S_ACC;
                        end else if (w_rd[4:3] == 2'b10 && w_rd[2:0] <= acc_cpu_pkg::JC_OVF
                                     && w_rd[7] != w_rd[5]) begin
                            // Jump or call: test the condition first.
                            case (w_rd[2:0])
                                acc_cpu_pkg::JC_ALW: cond_ok = 1'b1;
                                acc_cpu_pkg::JC_ZRO: cond_ok = (r_flg == acc_cpu_pkg::FLG_ZRO);
                                acc_cpu_pkg::JC_POS: cond_ok = (r_flg == acc_cpu_pkg::FLG_POS);
                                acc_cpu_pkg::JC_NEG: cond_ok = (r_flg == acc_cpu_pkg::FLG_NEG);
                                acc_cpu_pkg::JC_OVF: cond_ok = (r_flg == acc_cpu_pkg::FLG_OVF);
                                default:             cond_ok = 1'b0;
                            endcase
                            if (!cond_ok) begin
                                n_pc = r_pc + 16'd3;
                            end else if (w_rd[6]) begin
                                if ({1'b0, r_sp} + 17'd2 > acc_cpu_pkg::STACK_LIMIT) begin
                                    n_stop  = acc_cpu_pkg::RUN_FAULT;
                                    n_fault = acc_cpu_pkg::F_JUMP;
                                end else begin
                                    n_addr  = acc_cpu_pkg::STACK_BASE + r_sp;
                                    n_sys   = 1'b1;
                                    n_fc    = acc_cpu_pkg::F_JUMP;
                                    n_wdata = 8'((r_pc + 16'd3) >> 8);
                                    n_ph    = acc_cpu_pkg::P_PU0;
                                    n_state = acc_cpu_pkg::S_WR;
                                end
                            end else begin
                                n_addr  = r_pc + 16'd1;
                                n_sys   = w_rd[7];
                                n_fc    = acc_cpu_pkg::F_JUMP;
                                n_ph    = w_rd[7] ? acc_cpu_pkg::P_JA0 : acc_cpu_pkg::P_JD0;
                                n_state = acc_cpu_pkg::S_ACC;
                            end
                        end else begin
                            case (w_rd)
                                acc_cpu_pkg::OP_INC: begin
                                    n_acc = r_acc + 8'd1;
                                    n_flg = (r_acc == 8'hFF) ? acc_cpu_pkg::FLG_OVF
                                                             : acc_cpu_pkg::FLG_POS;
                                end
                                acc_cpu_pkg::OP_DEC: begin
                                    n_acc = r_acc - 8'd1;
                                    if (r_acc == 8'h01) begin
                                        n_flg = acc_cpu_pkg::FLG_ZRO;
                                    end else if (r_acc == 8'h00) begin
                                        n_flg = acc_cpu_pkg::FLG_NEG;
                                    end else begin
                                        n_flg = acc_cpu_pkg::FLG_POS;
                                    end
                                end
                                acc_cpu_pkg::OP_INX: begin
                                    n_idx = r_idx + 16'd1;
                                    n_flg = (r_idx == 16'hFFFF) ? acc_cpu_pkg::FLG_OVF
                                                                : acc_cpu_pkg::FLG_POS;
                                end
                                acc_cpu_pkg::OP_DEX: begin
                                    n_idx = r_idx - 16'd1;
                                    if (r_idx == 16'h0001) begin
                                        n_flg = acc_cpu_pkg::FLG_ZRO;
                                    end else if (r_idx == 16'h0000) begin
                                        n_flg = acc_cpu_pkg::FLG_NEG;
                                    end else begin
                                        n_flg = acc_cpu_pkg::FLG_POS;
                                    end
                                end
                                acc_cpu_pkg::OP_SHL: n_acc = {r_acc[6:0], 1'b0};
                                acc_cpu_pkg::OP_ROL: n_acc = {r_acc[6:0], r_acc[7]};
                                acc_cpu_pkg::OP_SHR: n_acc = {1'b0, r_acc[7:1]};
                                acc_cpu_pkg::OP_ROR: n_acc = {r_acc[0], r_acc[7:1]};
                                acc_cpu_pkg::OP_NOT: n_acc = ~r_acc;
                                acc_cpu_pkg::OP_RET: begin
                                    if (r_sp == 16'h0000) begin
                                        n_stop  = acc_cpu_pkg::RUN_FAULT;
                                        n_fault = acc_cpu_pkg::F_UNDER;
                                    end else begin
                                        n_sp    = r_sp - 16'd1;
                                        n_addr  = acc_cpu_pkg::STACK_BASE + r_sp - 16'd1;
                                        n_sys   = 1'b1;
                                        n_fc    = acc_cpu_pkg::F_LOAD;
                                        n_ph    = acc_cpu_pkg::P_RT0;
                                        n_state = acc_cpu_pkg::S_ACC;
                                    end
                                end
                                acc_cpu_pkg::OP_NOP: n_acc = r_acc;
                                acc_cpu_pkg::OP_HALT: n_stop = acc_cpu_pkg::RUN_HALT;
                                default: begin
                                    n_stop  = acc_cpu_pkg::RUN_FAULT;
                                    n_fault = acc_cpu_pkg::F_OPC;
                                end
                            endcase
                        end
                    end
                    acc_cpu_pkg::P_IMM: begin
                        n_pc  = r_pc + 16'd1;
                        n_acc = w_x_acc;
                        n_flg = w_x_flg;
                    end
                    acc_cpu_pkg::P_OPER: begin
                        n_acc = w_x_acc;
                        n_flg = w_x_flg;
                    end
                    acc_cpu_pkg::P_A0: begin
                        n_hi    = w_rd;
                        n_pc    = r_pc + 16'd1;
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_A1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_A1: begin
                        n_pc = r_pc + 16'd1;
                        ea   = {r_hi, w_rd};
                        if (r_mode == acc_cpu_pkg::MODE_DXI) begin
                            ea = {r_hi, w_rd} + r_idx;
                        end
                        if (r_mode == acc_cpu_pkg::MODE_PTR) begin
                            n_addr  = ea;
                            n_sys   = 1'b0;
                            n_fc    = acc_cpu_pkg::F_LOAD;
                            n_ph    = acc_cpu_pkg::P_PTR0;
                            n_state = acc_cpu_pkg::S_ACC;
                        end else begin
                            do_use = 1'b1;
                        end
                    end
                    acc_cpu_pkg::P_PTR0: begin
                        n_hi    = w_rd;
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_PTR1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_PTR1: begin
                        do_use = 1'b1;
                        ea     = {r_hi, w_rd};
                    end
                    acc_cpu_pkg::P_IX0: begin
                        n_idx   = {w_rd, r_idx[7:0]};
                        n_pc    = r_pc + 16'd1;
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_IX1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_IX1: begin
                        n_idx = {r_idx[15:8], w_rd};
                        n_pc  = r_pc + 16'd1;
                    end
                    acc_cpu_pkg::P_JA0: begin
                        n_hi    = w_rd;
                        n_pc    = r_pc + 16'd1;
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_JA1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_JA1: begin
                        n_pc    = r_pc + 16'd1;
                        n_addr  = {r_hi, w_rd};
                        n_sys   = 1'b0;
                        n_ph    = acc_cpu_pkg::P_JT0;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_JT0: begin
                        n_pc    = {w_rd, r_pc[7:0]};
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_JT1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_JT1: n_pc = {r_pc[15:8], w_rd};
                    acc_cpu_pkg::P_JD0: begin
                        n_hi    = w_rd;
                        n_pc    = r_pc + 16'd1;
                        n_addr  = r_addr + 16'd1;
                        n_ph    = acc_cpu_pkg::P_JD1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_JD1: n_pc = {r_hi, w_rd};
                    acc_cpu_pkg::P_RT0: begin
                        n_pc    = {r_pc[15:8], w_rd};
                        n_sp    = r_sp - 16'd1;
                        n_addr  = acc_cpu_pkg::STACK_BASE + r_sp - 16'd1;
                        n_ph    = acc_cpu_pkg::P_RT1;
                        n_state = acc_cpu_pkg::S_ACC;
                    end
                    acc_cpu_pkg::P_RT1: n_pc = {w_rd, r_pc[7:0]};
                    default: n_state = acc_cpu_pkg::S_DONE;
                endcase
            end

            // Write a byte if permitted, then continue by phase.
            acc_cpu_pkg::S_WR: begin
                n_state = acc_cpu_pkg::S_DONE;
                if (!acc_cpu_pkg::wr_ok(r_addr, r_sys)) begin
                    n_stop  = acc_cpu_pkg::RUN_FAULT;
                    n_fault = r_fc;
                end else begin
                    if (r_addr[15:8] == acc_cpu_pkg::CON_PAGE) begin
                        n_con_v = 1'b1;
                        n_con_c = r_wdata;
                        n_cstat = acc_cpu_pkg::CON_READY;
                    end else begin
                        w_we = 1'b1;
                    end
                    case (r_ph)
                        acc_cpu_pkg::P_SX0: begin
                            n_addr  = r_addr + 16'd1;
                            n_wdata = r_idx[7:0];
                            n_ph    = acc_cpu_pkg::P_SX1;
                            n_state = acc_cpu_pkg::S_WR;
                        end
                        acc_cpu_pkg::P_PU0: begin
                            n_sp    = r_sp + 16'd1;
                            n_addr  = acc_cpu_pkg::STACK_BASE + r_sp + 16'd1;
                            n_wdata = 8'(r_pc + 16'd2);
                            n_ph    = acc_cpu_pkg::P_PU1;
                            n_state = acc_cpu_pkg::S_WR;
                        end
                        acc_cpu_pkg::P_PU1: begin
                            n_sp   = r_sp + 16'd1;
                            jstart = 1'b1;
                        end
                        default: n_state = acc_cpu_pkg::S_DONE;
                    endcase
                end
            end

            // Hold the result until it is taken.
            acc_cpu_pkg::S_DONE: begin
                if (i_ready) begin
                    n_state = acc_cpu_pkg::S_IDLE;
                end
            end

            default: n_state = acc_cpu_pkg::S_IDLE;
        endcase

        // Target fetch of a call after its return address is pushed.
        if (jstart) begin
            n_addr  = r_pc;
            n_sys   = r_op[7];
            n_fc    = acc_cpu_pkg::F_JUMP;
            n_ph    = r_op[7] ? acc_cpu_pkg::P_JA0 : acc_cpu_pkg::P_JD0;
            n_state = acc_cpu_pkg::S_ACC;
        end

        // Use of an effective address: operand read or store.
        if (do_use) begin
            n_addr = ea;
            n_sys  = 1'b0;
            case (n_kind)
                acc_cpu_pkg::K_ST: begin
                    n_fc    = acc_cpu_pkg::F_STORE;
                    n_wdata = r_acc;
                    n_ph    = acc_cpu_pkg::P_ST;
                    n_state = acc_cpu_pkg::S_WR;
                end
                acc_cpu_pkg::K_STX: begin
                    n_fc    = acc_cpu_pkg::F_STORE;
                    n_wdata = r_idx[15:8];
                    n_ph    = acc_cpu_pkg::P_SX0;
                    n_state = acc_cpu_pkg::S_WR;
                end
                default: begin
                    n_fc    = acc_cpu_pkg::F_LOAD;
                    n_ph    = acc_cpu_pkg::P_OPER;
                    n_state = acc_cpu_pkg::S_ACC;
                end
            endcase
        end
    end

    // Control and architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acc_cpu_pkg::S_IDLE;
            r_acc   <= 8'h00;
            r_idx   <= 16'h0000;
            r_pc    <= 16'h0000;
            r_flg   <= 4'h0;
            r_sp    <= 16'h0000;
            r_cstat <= 8'h00;
            r_stop  <= acc_cpu_pkg::RUN_GO;
            r_fault <= acc_cpu_pkg::F_NONE;
            r_con_v <= 1'b0;
            r_con_c <= 8'h00;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_pc    <= n_pc;
            r_flg   <= n_flg;
            r_sp    <= n_sp;
            r_cstat <= n_cstat;
            r_stop  <= n_stop;
            r_fault <= n_fault;
            r_con_v <= n_con_v;
            r_con_c <= n_con_c;
        end
    end

    // Sequencer payload registers.
    always_ff @(posedge i_clk) begin
        r_ph    <= n_ph;
        r_kind  <= n_kind;
        r_mode  <= n_mode;
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_sys   <= n_sys;
        r_fc    <= n_fc;
        r_hi    <= n_hi;
        r_wdata <= n_wdata;
    end

    // Memory: one write port, one read port with registered data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (r_state == acc_cpu_pkg::S_ACC) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Ports.
    assign o_ready           = (r_state == acc_cpu_pkg::S_IDLE);
    assign o_valid           = (r_state == acc_cpu_pkg::S_DONE);
    assign o_run_state       = r_stop;
    assign o_fault_code      = r_fault;
    assign o_accumulator     = r_acc;
    assign o_index_value     = r_idx;
    assign o_flag_bits       = r_flg;
    assign o_program_counter = r_pc;
    assign o_console_valid   = r_con_v;
    assign o_console_char    = r_con_c;

    // Checks.
`include "accumulator_cpu_core_assert.svh"

    `ACC_CPU_ASSERT_IMP(a_one_beat, o_valid, !o_ready, "result and input open together")
    `ACC_CPU_ASSERT_IMP(a_con_status, o_valid && o_console_valid,
        r_cstat == acc_cpu_pkg::CON_READY, "console byte without ready status")
    `ACC_CPU_ASSERT_IMP(a_fault_pair, o_valid,
        (o_run_state == acc_cpu_pkg::RUN_FAULT) == (o_fault_code != acc_cpu_pkg::F_NONE),
        "fault code and run state disagree")
    `ACC_CPU_ASSERT_NXT(a_preload_fast, i_valid && o_ready && !i_command, o_valid,
        "preload result late")

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Accumulator CPU core testbench
// Sends preload and step beats to the core and checks every result beat
// against a cycle-free model of the instruction set kept inside this module.
// Programs are written on the fly: each instruction is placed at the current
// program counter, tried on a scratch copy of the model, and kept only when it
// runs cleanly, so the core keeps running until one deliberate fault at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acc_cpu_pkg::*;

    // Encodings that the package does not name.
    localparam logic [2:0] MODE_DIR = 3'd1;
    localparam logic [2:0] JM_JMP   = 3'd1;
    localparam logic [2:0] JM_CALL  = 3'd3;
    localparam logic [2:0] JM_IJMP  = 3'd4;
    localparam logic [2:0] JM_ICALL = 3'd6;
    localparam logic [1:0] JGRP     = 2'b10;
    localparam logic [7:0] OP_BAD   = 8'h01;
    localparam logic [15:0] CON_OUT_ADR = {CON_PAGE, CON_OUT_LO};
    localparam int ITEM_GOAL = 1550;

    typedef struct packed {
        logic [1:0]  run;
        logic [2:0]  flt;
        logic [7:0]  acc;
        logic [15:0] ix;
        logic [3:0]  flg;
        logic [15:0] pc;
        logic        cv;
        logic [7:0]  cc;
    } res_t;

    typedef struct {
        logic [7:0]  acc;
        logic [15:0] ix;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [3:0]  flg;
        logic [7:0]  cstat;
        logic [1:0]  run;
        logic [2:0]  flt;
        logic        cv;
        logic [7:0]  cc;
    } cpu_t;

    typedef struct {
        logic        cmd;
        logic [15:0] ad;
        logic [7:0]  d;
        logic        typed;
        res_t        r;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [15:0] i_address;
    logic [7:0]  i_data;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_run_state;
    logic [2:0]  o_fault_code;
    logic [7:0]  o_accumulator;
    logic [15:0] o_index_value;
    logic [3:0]  o_flag_bits;
    logic [15:0] o_program_counter;
    logic        o_console_valid;
    logic [7:0]  o_console_char;

    accumulator_cpu_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_address(i_address), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_run_state(o_run_state), .o_fault_code(o_fault_code),
        .o_accumulator(o_accumulator), .o_index_value(o_index_value),
        .o_flag_bits(o_flag_bits), .o_program_counter(o_program_counter),
        .o_console_valid(o_console_valid), .o_console_char(o_console_char)
    );

    // Model state: one byte array over the whole map plus a written mark.
    cpu_t        cpu;
    logic [7:0]  mem [0:65535];
    bit          mem_set [0:65535];
    logic [15:0] pend_ad [0:1];
    logic [7:0]  pend_d [0:1];
    int          pend_n;
    bit          miss;
    logic [15:0] miss_ad;

    res_t exp_q[$];
    int   errors;
    int   sent;
    int   steps_run;
    int   con_bytes;
    int   tx_pct;
    int   rx_pct;
    bit   hold_req;
    int   hold_cnt;

    // Read with the map rules; pending writes of this step come first.
    function automatic bit mem_get(input logic [15:0] ad, input bit sys,
                                   output logic [7:0] v);
        bit hit;
        hit = 0;
        v = 8'h00;
        if (ad[15:8] >= RAM_PAGE || ad[15:8] < PROT_LO_PAGE ||
            (ad[15:8] <= PROT_HI_PAGE && sys)) begin
            for (int i = 0; i < pend_n; i++) begin
                if (pend_ad[i] == ad) begin
                    v = pend_d[i];
                    hit = 1;
                end
            end
            if (!hit) begin
                if (!mem_set[ad] && !miss) begin
                    miss = 1;
                    miss_ad = ad;
                end
                v = mem[ad];
            end
            return 1;
        end
        if (ad[15:8] == CON_PAGE && ad[7:0] == CON_STAT_LO) begin
            v = cpu.cstat;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit mem_put(input logic [15:0] ad, input logic [7:0] v,
                                   input bit sys);
        if (ad[15:8] >= RAM_PAGE ||
            (ad[15:8] >= PROT_LO_PAGE && ad[15:8] <= PROT_HI_PAGE && sys)) begin
            pend_ad[pend_n] = ad;
            pend_d[pend_n] = v;
            pend_n++;
            return 1;
        end
        if (ad[15:8] == CON_PAGE && ad[7:0] == CON_OUT_LO) begin
            cpu.cv = 1'b1;
            cpu.cc = v;
            cpu.cstat = CON_READY;
            return 1;
        end
        return 0;
    endfunction

    // Two address bytes from the instruction stream, stack region allowed.
    function automatic bit fetch_word(output logic [15:0] w);
        logic [7:0] b0, b1;
        w = 16'h0;
        if (!mem_get(cpu.pc, 1, b0)) return 0;
        cpu.pc++;
        if (!mem_get(cpu.pc, 1, b1)) return 0;
        cpu.pc++;
        w = {b0, b1};
        return 1;
    endfunction

    function automatic int eff_address(input logic [2:0] md, output logic [15:0] ea);
        logic [7:0]  b0, b1;
        logic [15:0] w;
        ea = cpu.ix;
        if (md == MODE_IDX) return F_NONE;
        if (!fetch_word(w)) return F_FETCH;
        if (md == MODE_DXI) begin
            w = w + cpu.ix;
        end else if (md == MODE_PTR) begin
            if (!mem_get(w, 0, b0)) return F_LOAD;
            if (!mem_get(w + 16'd1, 0, b1)) return F_LOAD;
            w = {b0, b1};
        end
        ea = w;
        return F_NONE;
    endfunction

    function automatic int fetch_operand(input logic [2:0] md, output logic [7:0] v);
        logic [15:0] ea;
        int f;
        v = 8'h0;
        if (md == MODE_IMM) begin
            if (!mem_get(cpu.pc, 0, v)) return F_LOAD;
            cpu.pc++;
            return F_NONE;
        end
        f = eff_address(md, ea);
        if (f != F_NONE) return f;
        return mem_get(ea, 0, v) ? F_NONE : F_LOAD;
    endfunction

    // Conditional jump or call; 0 means the transfer failed.
    function automatic bit take_jump(input logic [7:0] op);
        logic [3:0]  want;
        bit          uncond;
        logic [7:0]  b0, b1;
        logic [15:0] w, ret_pc;
        uncond = 0;
        want = FLG_ZRO;
        case (op[2:0])
            JC_ALW: uncond = 1;
            JC_ZRO: want = FLG_ZRO;
            JC_POS: want = FLG_POS;
            JC_NEG: want = FLG_NEG;
            default: want = FLG_OVF;
        endcase
        if (!(uncond || cpu.flg == want)) begin
            cpu.pc += 16'd2;
            return 1;
        end
        if (op[6]) begin
            ret_pc = cpu.pc + 16'd2;
            if ({1'b0, cpu.sp} + 17'd2 > STACK_LIMIT) return 0;
            if (!mem_put(STACK_BASE + cpu.sp, ret_pc[15:8], 1)) return 0;
            cpu.sp++;
            if (!mem_put(STACK_BASE + cpu.sp, ret_pc[7:0], 1)) return 0;
            cpu.sp++;
        end
        if (op[7]) begin
            if (!fetch_word(w)) return 0;
            if (!mem_get(w, 0, b0)) return 0;
            cpu.pc[15:8] = b0;
            if (!mem_get(w + 16'd1, 0, b1)) return 0;
            cpu.pc = {b0, b1};
        end else begin
            if (!mem_get(cpu.pc, 0, b0)) return 0;
            cpu.pc++;
            if (!mem_get(cpu.pc, 0, b1)) return 0;
            cpu.pc = {b0, b1};
        end
        return 1;
    endfunction

    // One instruction; returns the fault code.
    function automatic int exec_instr();
        logic [7:0]  op, v, old;
        logic [2:0]  md;
        logic [4:0]  lo;
        logic [15:0] ea;
        int f;
        if (!mem_get(cpu.pc, 0, op)) return F_LOAD;
        cpu.pc++;
        md = op[7:5];
        lo = op[4:0];
        case (op)
            OP_NOP: return F_NONE;
            OP_HALT: begin
                cpu.run = RUN_HALT;
                return F_NONE;
            end
            OP_INC: begin
                cpu.acc++;
                cpu.flg = (cpu.acc == 8'h00) ? FLG_OVF : FLG_POS;
                return F_NONE;
            end
            OP_DEC: begin
                cpu.acc--;
                cpu.flg = (cpu.acc == 8'h00) ? FLG_ZRO :
                          (cpu.acc == 8'hFF) ? FLG_NEG : FLG_POS;
                return F_NONE;
            end
            OP_INX: begin
                cpu.ix++;
                cpu.flg = (cpu.ix == 16'h0) ? FLG_OVF : FLG_POS;
                return F_NONE;
            end
            OP_DEX: begin
                cpu.ix--;
                cpu.flg = (cpu.ix == 16'h0) ? FLG_ZRO :
                          (cpu.ix == 16'hFFFF) ? FLG_NEG : FLG_POS;
                return F_NONE;
            end
            OP_SHL: begin
                cpu.acc = cpu.acc << 1;
                return F_NONE;
            end
            OP_ROL: begin
                cpu.acc = {cpu.acc[6:0], cpu.acc[7]};
                return F_NONE;
            end
            OP_SHR: begin
                cpu.acc = cpu.acc >> 1;
                return F_NONE;
            end
            OP_ROR: begin
                cpu.acc = {cpu.acc[0], cpu.acc[7:1]};
                return F_NONE;
            end
            OP_NOT: begin
                cpu.acc = ~cpu.acc;
                return F_NONE;
            end
            OP_STX: begin
                if (!fetch_word(ea)) return F_FETCH;
                if (!mem_put(ea, cpu.ix[15:8], 0)) return F_STORE;
                return mem_put(ea + 16'd1, cpu.ix[7:0], 0) ? F_NONE : F_STORE;
            end
            OP_RET: begin
                if (cpu.sp == 16'h0) return F_UNDER;
                cpu.sp--;
                if (!mem_get(STACK_BASE + cpu.sp, 1, v)) return F_LOAD;
                cpu.pc[7:0] = v;
                cpu.sp--;
                if (!mem_get(STACK_BASE + cpu.sp, 1, v)) return F_LOAD;
                cpu.pc[15:8] = v;
                return F_NONE;
            end
            default: ;
        endcase
        if ((lo == LO_LD || lo == LO_ADD || lo == LO_SUB || lo == LO_AND ||
             lo == LO_OR || lo == LO_XOR) && md <= MODE_PTR) begin
            f = fetch_operand(md, v);
            if (f != F_NONE) return f;
            old = cpu.acc;
            case (lo)
                LO_LD:  cpu.acc = v;
                LO_ADD: begin
                    cpu.acc = old + v;
                    cpu.flg = (cpu.acc < old) ? FLG_OVF :
                              (cpu.acc == 8'h0) ? FLG_ZRO : FLG_POS;
                end
                LO_SUB: begin
                    cpu.acc = old - v;
                    cpu.flg = (cpu.acc == 8'h0) ? FLG_ZRO :
                              (cpu.acc > old) ? FLG_NEG : FLG_POS;
                end
                LO_AND: cpu.acc = old & v;
                LO_OR:  cpu.acc = old | v;
                default: cpu.acc = old ^ v;
            endcase
            return F_NONE;
        end
        if (lo == LO_ST && md >= MODE_DIR && md <= MODE_PTR) begin
            f = eff_address(md, ea);
            if (f != F_NONE) return f;
            return mem_put(ea, cpu.acc, 0) ? F_NONE : F_STORE;
        end
        if (lo == LO_LDX && md <= MODE_DIR) begin
            if (!mem_get(cpu.pc, 0, v)) return F_LOAD;
            cpu.pc++;
            cpu.ix[15:8] = v;
            if (!mem_get(cpu.pc, 0, v)) return F_LOAD;
            cpu.pc++;
            cpu.ix[7:0] = v;
            return F_NONE;
        end
        if (lo[4:3] == JGRP && lo[2:0] <= JC_OVF &&
            (md == JM_JMP || md == JM_CALL || md == JM_IJMP || md == JM_ICALL)) begin
            return take_jump(op) ? F_NONE : F_JUMP;
        end
        return F_OPC;
    endfunction

    // Applies one beat to the model; with keep low, a step's pending writes stay out of memory.
    function automatic res_t cpu_apply(input logic cmd, input logic [15:0] ad,
                                       input logic [7:0] d, input bit keep);
        int f;
        cpu.cv = 1'b0;
        cpu.cc = 8'h00;
        pend_n = 0;
        if (!cmd) begin
            if (ad == CON_STAT_ADR) begin
                cpu.cstat = d;
            end else begin
                mem[ad] = d;
                mem_set[ad] = 1;
            end
        end else if (cpu.run == RUN_GO) begin
            f = exec_instr();
            if (f != F_NONE) begin
                cpu.run = RUN_FAULT;
                cpu.flt = f[2:0];
            end
        end
        if (keep) begin
            for (int i = 0; i < pend_n; i++) begin
                mem[pend_ad[i]] = pend_d[i];
                mem_set[pend_ad[i]] = 1;
            end
        end
        return '{cpu.run, cpu.flt, cpu.acc, cpu.ix, cpu.flg, cpu.pc, cpu.cv, cpu.cc};
    endfunction

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 300;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_pct);
            end
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        res_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_run_state, o_fault_code, o_accumulator, o_index_value,
                    o_flag_bits, o_program_counter, o_console_valid, o_console_char};
            if (o_console_valid) con_bytes++;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat: %h", got);
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch at %0t", $realtime);
                        $display("  exp run=%0d flt=%0d acc=%h ix=%h flg=%h pc=%h con=%0d/%h",
                                 want.run, want.flt, want.acc, want.ix, want.flg,
                                 want.pc, want.cv, want.cc);
                        $display("  got run=%0d flt=%0d acc=%h ix=%h flg=%h pc=%h con=%0d/%h",
                                 got.run, got.flt, got.acc, got.ix, got.flg,
                                 got.pc, got.cv, got.cc);
                    end
                end
            end
        end
    end

    // Drives one beat; the expectation is queued before the beat goes out.
    task automatic send_item(input logic cmd, input logic [15:0] ad,
                             input logic [7:0] d, input bit typed = 0,
                             input res_t tr = '0);
        res_t p;
        p = cpu_apply(cmd, ad, d, 1);
        exp_q.push_back(typed ? tr : p);
        if (cmd) steps_run++;
        if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_address <= ad;
        i_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        if (sent == 400) hold_req = 1;
        tx_pct = (sent < ITEM_GOAL / 3) ? 29 : (sent < 2 * ITEM_GOAL / 3) ? 85 : 0;
        rx_pct = (sent < ITEM_GOAL / 3) ? 85 : (sent < 2 * ITEM_GOAL / 3) ? 29 : 0;
    endtask

    task automatic put_word(input logic [15:0] ad, input logic [15:0] w);
        send_item(0, ad, w[15:8]);
        send_item(0, ad + 16'd1, w[7:0]);
    endtask

    function automatic logic [15:0] code_adr();
        return $urandom_range(0, 1) ? 16'($urandom_range(16'h0010, 16'h2FF0))
                                    : 16'($urandom_range(16'h8000, 16'hBFF0));
    endfunction

    function automatic logic [15:0] data_adr();
        case ($urandom_range(0, 4))
            0, 1, 2: return 16'($urandom_range(16'hC000, 16'hFFFE));
            3:       return 16'($urandom_range(16'h3000, 16'h3FFE));
            default: return CON_STAT_ADR;
        endcase
    endfunction

    function automatic logic [15:0] store_adr();
        return ($urandom_range(0, 4) == 0) ? CON_OUT_ADR
                                          : 16'($urandom_range(16'hC000, 16'hFFFE));
    endfunction

    function automatic bit code_safe(input logic [15:0] pc);
        return pc <= 16'h3FF0 || (pc >= 16'h8000 && pc <= 16'hFFF0);
    endfunction

    // Writes one random instruction at the program counter, with its operands.
    task automatic place_instr();
        logic [15:0] pc, ptr, t;
        logic [2:0]  md;
        logic [7:0]  op;
        logic [4:0]  alu_lo [6];
        logic [7:0]  singles [11];
        logic [2:0]  jms [4];
        alu_lo = '{LO_LD, LO_ADD, LO_SUB, LO_AND, LO_OR, LO_XOR};
        singles = '{OP_INC, OP_DEC, OP_INX, OP_DEX, OP_SHL, OP_ROL, OP_SHR,
                    OP_ROR, OP_NOT, OP_NOP, OP_RET};
        jms = '{JM_JMP, JM_CALL, JM_IJMP, JM_ICALL};
        pc = cpu.pc;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                md = 3'($urandom_range(0, 4));
                op = {md, alu_lo[$urandom_range(0, 5)]};
                t = data_adr();
            end
            4: begin
                md = 3'($urandom_range(1, 4));
                op = {md, LO_ST};
                t = store_adr();
            end
            5: begin
                md = MODE_IMM;
                op = $urandom_range(0, 1) ? {3'($urandom_range(0, 1)), LO_LDX} : OP_STX;
                t = (op == OP_STX) ? 16'($urandom_range(16'hC000, 16'hFFFE))
                                   : ($urandom_range(0, 1) ? data_adr() : 16'($urandom));
            end
            6, 7: begin
                md = jms[$urandom_range(0, 3)];
                op = {md, JGRP, 3'($urandom_range(0, 4))};
                t = code_adr();
            end
            default: begin
                md = MODE_IMM;
                op = (cpu.sp != 0 && $urandom_range(0, 1)) ? OP_RET
                                                         : singles[$urandom_range(0, 10)];
                t = 16'h0;
            end
        endcase
        send_item(0, pc, op);
        if (op[4:0] == LO_LDX || op == OP_STX) begin
            put_word(pc + 16'd1, t);
        end else if (op[4:3] == JGRP && op != OP_RET) begin
            if (op[7]) begin
                ptr = 16'($urandom_range(16'hC000, 16'hFFFE));
                put_word(ptr, t);
                put_word(pc + 16'd1, ptr);
            end else begin
                put_word(pc + 16'd1, t);
            end
        end else if (op[4:0] == LO_LD || op[4:0] == LO_ADD || op[4:0] == LO_SUB ||
                     op[4:0] == LO_AND || op[4:0] == LO_OR || op[4:0] == LO_XOR ||
                     op[4:0] == LO_ST) begin
            case (md)
                MODE_IMM: send_item(0, pc + 16'd1, 8'($urandom));
                MODE_DIR: put_word(pc + 16'd1, t);
                MODE_DXI: put_word(pc + 16'd1, t - cpu.ix);
                MODE_PTR: begin
                    ptr = 16'($urandom_range(16'hC000, 16'hFFFE));
                    put_word(ptr, t);
                    put_word(pc + 16'd1, ptr);
                end
                default: ;
            endcase
        end
    endtask

    // Places instructions until one runs cleanly, or falls back to a jump after ten tries, then steps it.
    task automatic next_instr();
        cpu_t keep;
        res_t r;
        bit   ok;
        int   k;
        ok = 0;
        for (int tries = 0; tries < 10 && !ok; tries++) begin
            place_instr();
            k = 0;
            do begin
                keep = cpu;
                miss = 0;
                r = cpu_apply(1, 16'h0, 8'h0, 0);
                cpu = keep;
                if (miss) send_item(0, miss_ad, 8'($urandom));
                k++;
            end while (miss && k < 16);
            ok = !miss && r.run == RUN_GO && code_safe(r.pc);
        end
        if (!ok) begin
            send_item(0, cpu.pc, {JM_JMP, JGRP, JC_ALW});
            put_word(cpu.pc + 16'd1, code_adr());
        end
        send_item(1, 16'h0, 8'h0);
    endtask

    // Short program with known results, then index ops and console status.
    row_t plan [24] = '{
        '{0, 16'h0000, {MODE_IMM, LO_LD}, 1, '{RUN_GO, F_NONE, 8'h00, 16'h0, 4'h0, 16'h0, 1'b0, 8'h0}},
        '{0, 16'h0001, 8'hFF, 0, '0},
        '{1, 16'h0000, 8'h00, 1, '{RUN_GO, F_NONE, 8'hFF, 16'h0, 4'h0, 16'h2, 1'b0, 8'h0}},
        '{0, 16'h0002, OP_INC, 0, '0},
        '{1, 16'h0000, 8'h00, 1, '{RUN_GO, F_NONE, 8'h00, 16'h0, FLG_OVF, 16'h3, 1'b0, 8'h0}},
        '{0, 16'h0003, OP_DEC, 0, '0},
        '{1, 16'h0000, 8'h00, 1, '{RUN_GO, F_NONE, 8'hFF, 16'h0, FLG_NEG, 16'h4, 1'b0, 8'h0}},
        '{0, 16'h0004, {MODE_DIR, LO_ST}, 0, '0},
        '{0, 16'h0005, CON_PAGE, 0, '0},
        '{0, 16'h0006, CON_OUT_LO, 0, '0},
        '{1, 16'h0000, 8'h00, 1, '{RUN_GO, F_NONE, 8'hFF, 16'h0, FLG_NEG, 16'h7, 1'b1, 8'hFF}},
        '{0, 16'h0007, {MODE_IMM, LO_LDX}, 0, '0},
        '{0, 16'h0008, 8'hFF, 0, '0},
        '{0, 16'h0009, 8'hFF, 0, '0},
        '{1, 16'h0000, 8'h00, 0, '0},
        '{0, 16'h000A, OP_INX, 0, '0},
        '{1, 16'h0000, 8'h00, 0, '0},
        '{0, 16'h000B, OP_DEX, 0, '0},
        '{1, 16'h0000, 8'h00, 0, '0},
        '{0, CON_STAT_ADR, 8'h5A, 0, '0},
        '{0, 16'h000C, {MODE_DIR, LO_LD}, 0, '0},
        '{0, 16'h000D, CON_PAGE, 0, '0},
        '{0, 16'h000E, CON_STAT_LO, 0, '0},
        '{1, 16'h0000, 8'h00, 0, '0}
    };

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = 1'b0;
        i_address = 16'h0;
        i_data = 8'h0;
        errors = 0;
        sent = 0;
        steps_run = 0;
        con_bytes = 0;
        hold_req = 0;
        tx_pct = 29;
        rx_pct = 85;
        cpu = '{default: '0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            send_item(plan[i].cmd, plan[i].ad, plan[i].d, plan[i].typed, plan[i].r);
        end

        while (sent < ITEM_GOAL) begin
            if ($urandom_range(0, 9) == 0) send_item(0, 16'($urandom), 8'($urandom));
            next_instr();
            if (sent >= 900 && sent < 910) begin
                i_valid <= 1'b0;
                while (exp_q.size() != 0) @(posedge i_clk);
            end
        end

        // Deliberate stop: an undefined opcode, a step while stopped, a preload.
        send_item(0, cpu.pc, OP_BAD);
        send_item(1, 16'h0, 8'h0);
        send_item(1, 16'h0, 8'h0);
        send_item(0, 16'hFFFF, 8'hAA);

        i_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d beats: %0d instruction steps, %0d console bytes, final fault %0d.",
                 sent, steps_run, con_bytes, cpu.flt);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
